@@ hw/rtl/rpn_pkg.sv @@
`default_nettype none
package rpn_pkg;

  localparam int unsigned StackDepthDefault = 64;

  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StUnder   = 3'd1;
  localparam logic [2:0] StOver    = 3'd2;
  localparam logic [2:0] StDivZero = 3'd3;
  localparam logic [2:0] StZeroNeg = 3'd4;

  localparam logic [2:0] OpAdd = 3'd0;
  localparam logic [2:0] OpSub = 3'd1;
  localparam logic [2:0] OpMul = 3'd2;
  localparam logic [2:0] OpDiv = 3'd3;
  localparam logic [2:0] OpPow = 3'd4;

  typedef struct packed {
    logic        req_type;
    logic [30:0] number_value;
    logic [2:0]  op_code;
    logic        last_token;
  } rpn_req_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [2:0]         status;
  } rpn_rsp_t;

  typedef struct packed {
    logic        start;
    logic [2:0]  op_code;
    logic [31:0] left;
    logic [31:0] right;
  } alu_cmd_t;

  typedef struct packed {
    logic        done;
    logic [31:0] result;
    logic [2:0]  error;
  } alu_rsp_t;

  typedef enum logic [3:0] {
    SIdle,
    SRead1,
    SRead2,
    SWait,
    SAluStart,
    SAluRun,
    SWrite,
    SLastRead,
    SLastWait,
    SOut
  } ctrl_state_e;

  typedef enum logic [2:0] {
    AIdle,
    ADiv,
    APow,
    ADone
  } alu_state_e;

endpackage
`default_nettype wire

@@ hw/rtl/rpn_ram.sv @@
`default_nettype none
module rpn_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

@@ hw/rtl/rpn_alu.sv @@
`default_nettype none
module rpn_alu
  import rpn_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire alu_cmd_t cmd_i,
  output alu_rsp_t      rsp_o
);

  alu_state_e state_q, state_d;
  logic [31:0] res_q, res_d;
  logic [2:0]  err_q, err_d;
  logic [31:0] a_q, a_d;
  logic [31:0] b_q, b_d;
  logic [31:0] rem_q, rem_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        neg_q, neg_d;
  logic        phase_q, phase_d;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [32:0] trial;
  logic [31:0] rem_sh;
  logic [31:0] la, ra;

  assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};
  assign rem_sh = {rem_q[30:0], a_q[31]};
  assign trial = {1'b0, rem_sh} - {1'b0, b_q};
  assign la = cmd_i.left[31] ? (32'd0 - cmd_i.left) : cmd_i.left;
  assign ra = cmd_i.right[31] ? (32'd0 - cmd_i.right) : cmd_i.right;

  always_comb begin
    mul_a = res_q;
    mul_b = a_q;
    if (state_q == AIdle) begin
      mul_a = cmd_i.left;
      mul_b = cmd_i.right;
    end else if (phase_q) begin
      mul_a = a_q;
      mul_b = a_q;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      AIdle: begin
        if (cmd_i.start) begin
          if ((cmd_i.op_code == OpDiv) && (cmd_i.right != 32'd0)) begin
            state_d = ADiv;
          end else if ((cmd_i.op_code == OpPow) && !cmd_i.right[31]
                       && (cmd_i.right != 32'd0)) begin
            state_d = APow;
          end else begin
            state_d = ADone;
          end
        end
      end
      ADiv: if (cnt_q == 6'd31) state_d = ADone;
      APow: if (phase_q && (b_q[31:1] == 31'd0)) state_d = ADone;
      ADone: state_d = AIdle;
      default: state_d = AIdle;
    endcase
  end

  always_comb begin
    res_d = res_q;
    err_d = err_q;
    a_d = a_q;
    b_d = b_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    neg_d = neg_q;
    phase_d = phase_q;
    case (state_q)
      AIdle: begin
        if (cmd_i.start) begin
          err_d = StOk;
          cnt_d = '0;
          rem_d = '0;
          phase_d = 1'b0;
          case (cmd_i.op_code)
            OpAdd: res_d = cmd_i.left + cmd_i.right;
            OpSub: res_d = cmd_i.left - cmd_i.right;
            OpMul: res_d = mul_p[31:0];
            OpDiv: begin
              a_d = la;
              b_d = ra;
              res_d = '0;
              neg_d = cmd_i.left[31] ^ cmd_i.right[31];
              if (cmd_i.right == 32'd0) err_d = StDivZero;
            end
            OpPow: begin
              a_d = cmd_i.left;
              b_d = cmd_i.right;
              res_d = 32'd1;
              if (cmd_i.right[31]) begin
                if (cmd_i.left == 32'd1) begin
                  res_d = 32'd1;
                end else if (cmd_i.left == 32'hFFFF_FFFF) begin
                  res_d = cmd_i.right[0] ? 32'hFFFF_FFFF : 32'd1;
                end else begin
                  res_d = '0;
                  if (cmd_i.left == 32'd0) err_d = StZeroNeg;
                end
              end
            end
            default: res_d = '0;
          endcase
        end
      end
      ADiv: begin
        a_d = {a_q[30:0], 1'b0};
        cnt_d = cnt_q + 6'd1;
        if (!trial[32]) begin
          rem_d = trial[31:0];
          res_d = {res_q[30:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          res_d = {res_q[30:0], 1'b0};
        end
        if ((cnt_q == 6'd31) && neg_q) begin
          res_d = 32'd0 - (!trial[32] ? {res_q[30:0], 1'b1} : {res_q[30:0], 1'b0});
        end
      end
      APow: begin
        if (!phase_q) begin
          if (b_q[0]) res_d = mul_p[31:0];
        end else begin
          a_d = mul_p[31:0];
          b_d = {1'b0, b_q[31:1]};
        end
        phase_d = !phase_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= AIdle;
      phase_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    err_q <= err_d;
    a_q <= a_d;
    b_q <= b_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
  end

  always_comb begin
    rsp_o.done = (state_q == ADone);
    rsp_o.result = res_q;
    rsp_o.error = err_q;
  end

endmodule
`default_nettype wire

@@ hw/rtl/rpn_stack_evaluator_core.sv @@
// A push is written to the stack from the idle state; an operator reads the top two stack
// entries, starts the ALU and writes the result back, and the ALU iterates for divide and power.
// A last token then adds the top-of-stack read and the response register.
// One request at a time; the block is not ready while a request is in work.
// Reset clears the stack count, the error code and the order register; stack contents
// are not cleared.
`default_nettype none
module rpn_stack_evaluator_core
  import rpn_pkg::*;
#(
  parameter int unsigned StackDepth = StackDepthDefault
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     cfg_valid_i,
  output logic          cfg_ready_o,
  input  wire logic     cfg_data_i,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire rpn_req_t in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output rpn_rsp_t      out_data_o
);

  localparam int unsigned AddrW = $clog2(StackDepth);
  localparam int unsigned CntW = $clog2(StackDepth + 1);
  localparam logic [CntW-1:0] DepthC = CntW'(StackDepth);

  ctrl_state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [2:0]      err_q, err_d;
  logic            prefix_q;
  rpn_req_t        req_q;
  logic [31:0]     top_q, top_d;
  rpn_rsp_t        rsp_q, rsp_d;
  logic            out_valid_q, out_valid_d;
  logic            we;
  logic [AddrW-1:0] waddr, raddr;
  logic [31:0]     wdata, rdata;
  alu_cmd_t        cmd;
  alu_rsp_t        alu_rsp;

  rpn_ram #(.Width(32), .Depth(StackDepth)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  rpn_alu u_alu (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd),
    .rsp_o (alu_rsp)
  );

  assign cfg_ready_o = (state_q == SIdle);
  assign in_ready_o = (state_q == SIdle) && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o = rsp_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      SIdle: begin
        if (in_valid_i && in_ready_o) begin
          if (in_data_i.req_type == 1'b0) begin
            state_d = in_data_i.last_token ? SLastRead : SIdle;
          end else if (cnt_q < CntW'(2)) begin
            state_d = in_data_i.last_token ? SLastRead : SIdle;
          end else begin
            state_d = SRead1;
          end
        end
      end
      SRead1: state_d = SRead2;
      SRead2: state_d = SWait;
      SWait: state_d = SAluStart;
      SAluStart: state_d = SAluRun;
      SAluRun: if (alu_rsp.done) state_d = SWrite;
      SWrite: state_d = req_q.last_token ? SLastRead : SIdle;
      SLastRead: state_d = SLastWait;
      SLastWait: state_d = SOut;
      SOut: state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    err_d = err_q;
    top_d = top_q;
    rsp_d = rsp_q;
    out_valid_d = out_valid_q;
    we = 1'b0;
    waddr = cnt_q[AddrW-1:0];
    wdata = 32'd0;
    raddr = AddrW'(cnt_q - CntW'(1));
    cmd = '0;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    case (state_q)
      SIdle: begin
        if (in_valid_i && in_ready_o) begin
          if (in_data_i.req_type == 1'b0) begin
            if (cnt_q >= DepthC) begin
              if (err_q == StOk) err_d = StOver;
            end else begin
              we = 1'b1;
              wdata = {1'b0, in_data_i.number_value};
              cnt_d = cnt_q + CntW'(1);
            end
          end else if (cnt_q < CntW'(2)) begin
            if (err_q == StOk) err_d = StUnder;
          end
        end
      end
      SRead1: raddr = AddrW'(cnt_q - CntW'(1));
      SRead2: begin
        raddr = AddrW'(cnt_q - CntW'(2));
        top_d = rdata;
      end
      SWait: raddr = AddrW'(cnt_q - CntW'(2));
      SAluStart: begin
        cmd.start = 1'b1;
        cmd.op_code = req_q.op_code;
        cmd.left = prefix_q ? top_q : rdata;
        cmd.right = prefix_q ? rdata : top_q;
      end
      SWrite: begin
        we = 1'b1;
        waddr = AddrW'(cnt_q - CntW'(2));
        wdata = alu_rsp.result;
        cnt_d = cnt_q - CntW'(1);
        if (err_q == StOk) err_d = alu_rsp.error;
      end
      SOut: begin
        out_valid_d = 1'b1;
        rsp_d.status = err_q;
        rsp_d.result_value = '0;
        if (cnt_q == '0) begin
          if (err_q == StOk) rsp_d.status = StUnder;
        end else if (err_q == StOk) begin
          rsp_d.result_value = rdata;
        end
        cnt_d = '0;
        err_d = StOk;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      cnt_q <= '0;
      err_q <= StOk;
      prefix_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      err_q <= err_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) prefix_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
    rsp_q <= rsp_d;
    if (in_valid_i && in_ready_o) req_q <= in_data_i;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= DepthC)
    else $error("stack count beyond depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SOut) |=> (cnt_q == '0) && (err_q == StOk))
    else $error("stack not cleared after last token");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (rsp_q.status != StOk)) |-> (rsp_q.result_value == '0))
    else $error("nonzero value with error status");

endmodule
`default_nettype wire

@@ dv/rpn_stack_evaluator_core_tb.sv @@
`timescale 1ns / 100ps
`default_nettype none
module rpn_stack_evaluator_core_tb
  import rpn_pkg::*;
();

  localparam int Depth = 64;

  logic     clk;
  logic     rst_n;
  logic     cfg_valid;
  logic     cfg_ready;
  logic     cfg_data;
  logic     in_valid;
  logic     in_ready;
  rpn_req_t in_data;
  logic     out_valid;
  logic     out_ready;
  rpn_rsp_t out_data;

  rpn_stack_evaluator_core DUT (
    .clk_i(clk),
    .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i(cfg_data),
    .in_valid_i(in_valid),
    .in_ready_o(in_ready),
    .in_data_i(in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o(out_data)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  logic [31:0] calc_stack [Depth];
  int          calc_count;
  logic [2:0]  calc_error;
  logic        calc_prefix;
  rpn_rsp_t    pending_results [$];
  int          error_count;
  bit          stall_mode;

  function automatic void flag_error(input logic [2:0] code);
    if (calc_error == StOk) calc_error = code;
  endfunction

  function automatic logic [31:0] int_power(input logic [31:0] base, input logic [31:0] expo);
    logic [31:0] acc;
    logic [31:0] sq;
    acc = 32'd1;
    sq = base;
    if (expo[31]) begin
      if (base == 32'd1) return 32'd1;
      if (base == 32'hFFFF_FFFF) return expo[0] ? 32'hFFFF_FFFF : 32'd1;
      if (base == 32'd0) flag_error(StZeroNeg);
      return 32'd0;
    end
    while (expo != 0) begin
      if (expo[0]) acc = acc * sq;
      sq = sq * sq;
      expo = expo >> 1;
    end
    return acc;
  endfunction

  function automatic logic [31:0] apply_op(input logic [31:0] l, input logic [31:0] r,
                                           input logic [2:0] op);
    case (op)
      OpAdd: return l + r;
      OpSub: return l - r;
      OpMul: return l * r;
      OpDiv: begin
        if (r == 0) begin
          flag_error(StDivZero);
          return 32'd0;
        end
        return 32'($signed({l[31], l}) / $signed({r[31], r}));
      end
      OpPow: return int_power(l, r);
      default: return 32'd0;
    endcase
  endfunction

  function automatic void predict_token(input rpn_req_t t);
    logic [31:0] a;
    logic [31:0] b;
    rpn_rsp_t    res;
    if (!t.req_type) begin
      if (calc_count >= Depth) flag_error(StOver);
      else begin
        calc_stack[calc_count] = {1'b0, t.number_value};
        calc_count++;
      end
    end else if (calc_count < 2) begin
      flag_error(StUnder);
    end else begin
      a = calc_stack[calc_count - 1];
      b = calc_stack[calc_count - 2];
      calc_count--;
      calc_stack[calc_count - 1] = calc_prefix ? apply_op(a, b, t.op_code)
                                               : apply_op(b, a, t.op_code);
    end
    if (!t.last_token) return;
    res.result_value = 0;
    if (calc_count == 0) flag_error(StUnder);
    else if (calc_error == StOk) res.result_value = calc_stack[calc_count - 1];
    res.status = calc_error;
    if (res.status != StOk) res.result_value = 0;
    pending_results = {pending_results, res};
    calc_count = 0;
    calc_error = StOk;
  endfunction

  always @(negedge clk) begin
    if (stall_mode) out_ready <= ($urandom_range(0, 3) != 0);
    else out_ready <= 1'b1;
  end

  always @(posedge clk) begin
    rpn_rsp_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= 10) $display("Unexpected result %0d status %0d",
                                        out_data.result_value, out_data.status);
      end else begin
        exp_res = pending_results.pop_front();
        if (out_data.result_value !== exp_res.result_value ||
            out_data.status !== exp_res.status) begin
          error_count++;
          if (error_count <= 10)
            $display("Mismatch: expected %0d/%0d, got %0d/%0d", exp_res.result_value,
                     exp_res.status, out_data.result_value, out_data.status);
        end
      end
    end
  end

  task automatic send_token(input rpn_req_t t);
    in_data <= t;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_token(t);
    @(negedge clk);
  endtask

  task automatic write_order(input logic v);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    calc_prefix = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic rpn_req_t num_tok(input logic [30:0] v, input logic last);
    rpn_req_t t;
    t = '0;
    t.number_value = v;
    t.last_token = last;
    return t;
  endfunction

  function automatic rpn_req_t op_tok(input logic [2:0] op, input logic last);
    rpn_req_t t;
    t = '0;
    t.req_type = 1'b1;
    t.op_code = op;
    t.last_token = last;
    t.number_value = 31'($urandom());
    return t;
  endfunction

  function automatic rpn_req_t random_token(input int depth);
    rpn_req_t t;
    logic [30:0] v;
    case ($urandom_range(0, 3))
      0: v = 31'($urandom_range(0, 3));
      1: v = 31'h7FFF_FFFF - 31'($urandom_range(0, 2));
      default: v = 31'($urandom());
    endcase
    if (depth < 2 || $urandom_range(0, 9) < 4) t = num_tok(v, 1'b0);
    else t = op_tok(3'($urandom_range(0, 7)), 1'b0);
    if (t.req_type && $urandom_range(0, 2) == 0) t.op_code = 3'($urandom_range(0, 4));
    return t;
  endfunction

  typedef struct {
    rpn_req_t    tok;
    bit          known;
    logic [31:0] value;
    logic [2:0]  status;
  } stim_row_t;

  stim_row_t directed_rows [$];

  task automatic add_row(input rpn_req_t t, input bit k, input logic [31:0] v,
                         input logic [2:0] s);
    stim_row_t r;
    r.tok = t;
    r.known = k;
    r.value = v;
    r.status = s;
    directed_rows = {directed_rows, r};
  endtask

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int gap;
    int burst;
    int depth;
    int sent;
    stim_row_t r;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b1;
    stall_mode = 1'b0;
    error_count = 0;
    calc_count = 0;
    calc_error = StOk;
    calc_prefix = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    add_row(num_tok(31'h7FFF_FFFF, 1'b1), 1, 32'h7FFF_FFFF, StOk);
    add_row(op_tok(OpAdd, 1'b1), 1, 0, StUnder);
    add_row(num_tok(0, 1'b0), 0, 0, 0);
    add_row(num_tok(0, 1'b0), 0, 0, 0);
    add_row(op_tok(OpDiv, 1'b1), 1, 0, StDivZero);
    add_row(num_tok(0, 1'b0), 0, 0, 0);
    add_row(num_tok(0, 1'b0), 0, 0, 0);
    add_row(num_tok(1, 1'b0), 0, 0, 0);
    add_row(op_tok(OpSub, 1'b0), 0, 0, 0);
    add_row(op_tok(OpPow, 1'b1), 1, 0, StZeroNeg);
    add_row(num_tok(7, 1'b0), 0, 0, 0);
    add_row(num_tok(3, 1'b0), 0, 0, 0);
    add_row(op_tok(OpMul, 1'b0), 0, 0, 0);
    add_row(num_tok(0, 1'b0), 0, 0, 0);
    add_row(op_tok(OpPow, 1'b0), 0, 0, 0);
    add_row(num_tok(2, 1'b0), 0, 0, 0);
    add_row(op_tok(3'd6, 1'b1), 0, 0, 0);
    add_row(num_tok(5, 1'b0), 0, 0, 0);
    add_row(op_tok(OpAdd, 1'b0), 0, 0, 0);
    add_row(op_tok(OpPow, 1'b1), 0, 0, 0);
    foreach (directed_rows[i]) begin
      r = directed_rows[i];
      send_token(r.tok);
      if (r.known && (pending_results[$].result_value !== r.value ||
                      pending_results[$].status !== r.status)) begin
        error_count++;
        if (error_count <= 10) $display("Directed row %0d predicts wrong", i);
      end
    end

    for (int n = 0; n < 66; n++) send_token(num_tok(31'(n), n == 65));

    stall_mode = 1'b1;
    sent = 0;
    depth = 0;
    for (int phase = 0; phase < 4; phase++) begin
      write_order(phase[0] ? 1'b0 : 1'b1);
      while (sent < (phase + 1) * 125) begin
        burst = $urandom_range(1, 12);
        for (int k = 0; k < burst; k++) begin
          rpn_req_t t;
          t = random_token(depth);
          if ($urandom_range(0, 5) == 0) t.last_token = 1'b1;
          if (t.req_type) depth = (depth >= 2) ? depth - 1 : depth;
          else depth++;
          if (t.last_token) depth = 0;
          send_token(t);
          sent++;
        end
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        if (sent % 100 < 12 && pending_results.size() != 0) begin
          if (gap == 0) in_valid <= 1'b0;
          while (pending_results.size() != 0) @(negedge clk);
        end
      end
      send_token(op_tok(OpAdd, 1'b1));
      depth = 0;
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire
